@@ rtl/tccw_pkg.sv @@
// shared constants and field widths for the text console cursor writer
`timescale 1ns / 1ps
`default_nettype none
package tccw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // transfer field widths
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int ADDR_IN_W   = 11;
    localparam int WORD_W      = 16;
    localparam int CUR_ROW_W   = 5;
    localparam int CUR_COL_W   = 7;
    localparam int ATTR_W      = 8;

    // address width wide enough to compare against the cell count
    localparam int ADDR_CMP_W = (ADDR_IN_W > ADDR_W + 1) ? ADDR_IN_W : ADDR_W + 1;

    // op codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [WORD_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

endpackage
`default_nettype wire

@@ rtl/tccw_cmd_if.sv @@
// command channel: op, character and cell address
`timescale 1ns / 1ps
`default_nettype none
interface tccw_cmd_if;
    import tccw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [CHAR_W-1:0]    char_code;
    logic [ADDR_IN_W-1:0] cell_address;

    modport source (output valid, output op, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_address,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/tccw_rsp_if.sv @@
// response channel: cell word and cursor position
`timescale 1ns / 1ps
`default_nettype none
interface tccw_rsp_if;
    import tccw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    cell_word;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;

    modport source (output valid, output cell_word, output cursor_row, output cursor_col,
                    input ready);
    modport sink   (input valid, input cell_word, input cursor_row, input cursor_col,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/text_console_cursor_writer_unit.sv @@
// text console: screen cell memory, cursor and scroll/clear sequencer
// steps: a put is handled from idle; a read makes one memory read, then answers; clear
// walks every cell; a scrolling put moves one cell per cycle, then blanks the last row
// throughput: one put per cycle unless held by the response or a scroll; every item is
// handled alone, bound by the single read and single write port of the cell memory
// reset: cursor homed, attribute 7, then a clearing pass writes every cell; no item is
// taken during it, configuration writes are
`timescale 1ns / 1ps
`default_nettype none
module text_console_cursor_writer_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [tccw_pkg::ATTR_W-1:0] i_cfg_wr_data,
    tccw_cmd_if.sink                         i_cmd,
    tccw_rsp_if.source                       o_rsp
);
    import tccw_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_FILL   = 7'b0000100,
        S_SCROLL = 7'b0001000,
        S_BLANK  = 7'b0010000,
        S_READ   = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] BLANK_START = ADDR_W'((ROWS - 1) * COLUMNS);

    logic [WORD_W-1:0] r_mem [0:CELL_COUNT-1];
    logic [WORD_W-1:0] r_mem_q;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic                r_rd_ok, n_rd_ok;
    logic [ATTR_W-1:0]   r_attr;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic [CUR_ROW_W-1:0] r_out_row;
    logic [CUR_COL_W-1:0] r_out_col;

    logic                  w_accept;
    logic [WORD_W-1:0]     w_blank;
    logic                  w_we, w_re;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    logic [WORD_W-1:0]     w_wdata;
    logic                  w_done;
    logic [WORD_W-1:0]     w_done_word;
    logic [ADDR_CMP_W-1:0] w_addr_ext;

    // put decode
    logic [ADDR_W-1:0] w_cur_idx;
    logic [COL_W:0]    w_col_inc, w_col_tab;
    logic              w_adv_row;
    logic              w_put_we;
    logic [ADDR_W-1:0] w_put_waddr;
    logic [WORD_W-1:0] w_put_wdata;
    logic [COL_W-1:0]  w_put_col;
    logic [ROW_W-1:0]  w_put_row;
    logic              w_put_scroll;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_blank    = {r_attr, CH_SPACE};
    assign w_addr_ext = ADDR_CMP_W'(i_cmd.cell_address);
    assign w_cur_idx  = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign w_col_inc  = {1'b0, r_col} + (COL_W+1)'(1);
    assign w_col_tab  = ({1'b0, r_col} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);

    assign i_cmd.ready     = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.cell_word = r_out_word;
    assign o_rsp.cursor_row = r_out_row;
    assign o_rsp.cursor_col = r_out_col;

    always_comb begin
        w_put_we    = 1'b0;
        w_put_waddr = w_cur_idx;
        w_put_wdata = {r_attr, i_cmd.char_code};
        w_put_col   = r_col;
        w_adv_row   = 1'b0;
        case (i_cmd.char_code)
            CH_LF: begin
                w_put_col = '0;
                w_adv_row = 1'b1;
            end
            CH_CR: begin
                w_put_col = '0;
            end
            CH_BS: begin
                if (r_col != '0) begin
                    w_put_col   = r_col - COL_W'(1);
                    w_put_we    = 1'b1;
                    w_put_waddr = w_cur_idx - ADDR_W'(1);
                    w_put_wdata = w_blank;
                end
            end
            CH_TAB: begin
                if (w_col_tab >= (COL_W+1)'(COLUMNS)) begin
                    w_put_col = '0;
                    w_adv_row = 1'b1;
                end else begin
                    w_put_col = w_col_tab[COL_W-1:0];
                end
            end
            default: begin
                w_put_we = 1'b1;
                if (w_col_inc >= (COL_W+1)'(COLUMNS)) begin
                    w_put_col = '0;
                    w_adv_row = 1'b1;
                end else begin
                    w_put_col = w_col_inc[COL_W-1:0];
                end
            end
        endcase
        // past the bottom row the screen scrolls and the cursor stays on the last row
        w_put_row    = r_row;
        w_put_scroll = 1'b0;
        if (w_adv_row) begin
            if (r_row == ROW_W'(ROWS - 1)) begin
                w_put_scroll = 1'b1;
            end else begin
                w_put_row = r_row + ROW_W'(1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_rd_ok     = r_rd_ok;
        w_we        = 1'b0;
        w_waddr     = r_cnt;
        w_wdata     = w_blank;
        w_re        = 1'b0;
        w_raddr     = w_addr_ext[ADDR_W-1:0];
        w_done      = 1'b0;
        w_done_word = '0;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = RESET_BLANK;
                if (r_cnt == LAST_CELL) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.op)
                        OP_PUT: begin
                            w_we    = w_put_we;
                            w_waddr = w_put_waddr;
                            w_wdata = w_put_wdata;
                            n_row   = w_put_row;
                            n_col   = w_put_col;
                            if (w_put_scroll) begin
                                n_state = S_SCROLL;
                                n_cnt   = '0;
                            end else begin
                                w_done = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_cnt   = '0;
                            n_state = S_FILL;
                        end
                        OP_READ: begin
                            w_re    = 1'b1;
                            n_rd_ok = w_addr_ext < ADDR_CMP_W'(CELL_COUNT);
                            n_state = S_READ;
                        end
                        default: begin
                            w_done = 1'b1;
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we = 1'b1;
                if (r_cnt == LAST_CELL) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_SCROLL: begin
                // read one row ahead, write the cell read last cycle one row up
                if (r_cnt != SCROLL_LAST) begin
                    w_re    = 1'b1;
                    w_raddr = r_cnt + ADDR_W'(COLUMNS);
                end
                if (r_cnt != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_cnt - ADDR_W'(1);
                    w_wdata = r_mem_q;
                end
                if (r_cnt == SCROLL_LAST) begin
                    n_state = S_BLANK;
                    n_cnt   = BLANK_START;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_BLANK: begin
                w_we = 1'b1;
                if (r_cnt == LAST_CELL) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_READ: begin
                w_done      = 1'b1;
                w_done_word = r_rd_ok ? r_mem_q : '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cell memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_rd_ok     <= 1'b0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
            r_rd_ok <= n_rd_ok;
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_word <= w_done_word;
            r_out_row  <= CUR_ROW_W'(n_row);
            r_out_col  <= CUR_COL_W'(n_col);
        end
    end

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS))
        else $error("cursor outside the screen");

    a_clear_starts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.op == OP_CLEAR) |=> (r_state == S_FILL && r_cnt == '0))
        else $error("clear did not start the fill walk");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (32'(w_waddr) < CELL_COUNT))
        else $error("memory write outside the screen");

    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_state == S_IDLE))
        else $error("result raised while a walk is in progress");

    a_scroll_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("scroll read and write hit the same cell");

endmodule
`default_nettype wire

@@ tb/tb_text_console_cursor_writer_unit.sv @@
// self-checking testbench for the text console cursor writer: directed table, then random traffic
`timescale 1ns / 1ps
module tb_text_console_cursor_writer_unit;
    import tccw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CLK_PERIOD       = 8;
    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int RANDOM_PER_PHASE = 325;
    localparam int SETTLE_CYCLES    = CELL_COUNT + 16;
    localparam int HOLD_CYCLES      = 400;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [WORD_W-1:0]    cell_word;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_col;
    } console_result_t;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [CHAR_W-1:0]    char_code;
        logic [ADDR_IN_W-1:0] cell_address;
        int unsigned          repeats;
        bit                   pinned;
        console_result_t      pinned_result;
    } directed_row_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [ATTR_W-1:0] i_cfg_wr_data = '0;

    tccw_cmd_if cmd_bus ();
    tccw_rsp_if rsp_bus ();

    text_console_cursor_writer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd_bus),
        .o_rsp         (rsp_bus)
    );

    // screen shadow and cursor
    logic [WORD_W-1:0] screen_model [CELL_COUNT];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [ATTR_W-1:0] attr_model;

    console_result_t pending_results [$];
    directed_row_t   directed_rows [$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_model[i] = {attr_model, CH_SPACE};
        end
    endfunction

    function automatic int unsigned cursor_cell();
        int unsigned idx;
        idx = cur_row * COLUMNS + cur_col;
        return (idx < CELL_COUNT) ? idx : 0;
    endfunction

    function automatic console_result_t apply_command(input logic [OP_W-1:0] op,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [ADDR_IN_W-1:0] addr);
        console_result_t res;
        res = '0;
        case (op)
            OP_PUT: begin
                case (ch)
                    CH_LF: begin
                        cur_col = 0;
                        cur_row++;
                    end
                    CH_CR: cur_col = 0;
                    CH_BS: begin
                        if (cur_col > 0) begin
                            cur_col--;
                            screen_model[cursor_cell()] = {attr_model, CH_SPACE};
                        end
                    end
                    CH_TAB: begin
                        cur_col = (cur_col + 4) & ~32'd3;
                        if (cur_col >= COLUMNS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    default: begin
                        screen_model[cursor_cell()] = {attr_model, ch};
                        cur_col++;
                        if (cur_col >= COLUMNS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                endcase
                // scroll up one row, blank the bottom row
                if (cur_row >= ROWS) begin
                    for (int i = 0; i + COLUMNS < CELL_COUNT; i++) begin
                        screen_model[i] = screen_model[i + COLUMNS];
                    end
                    for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
                        screen_model[i] = {attr_model, CH_SPACE};
                    end
                    cur_row = ROWS - 1;
                end
            end
            OP_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: begin
                if (addr < CELL_COUNT) begin
                    res.cell_word = screen_model[addr];
                end
            end
            default: ;
        endcase
        res.cursor_row = CUR_ROW_W'(cur_row);
        res.cursor_col = CUR_COL_W'(cur_col);
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    task automatic table_row(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [ADDR_IN_W-1:0] addr, input int unsigned repeats,
                             input bit pinned, input logic [WORD_W-1:0] word,
                             input int unsigned row, input int unsigned col);
        directed_row_t r;
        r.op            = op;
        r.char_code     = ch;
        r.cell_address  = addr;
        r.repeats       = repeats;
        r.pinned        = pinned;
        r.pinned_result = {word, CUR_ROW_W'(row), CUR_COL_W'(col)};
        directed_rows.push_back(r);
    endtask

    // starts and ends on a falling edge
    task automatic issue_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                 input logic [ADDR_IN_W-1:0] addr, input bit pinned,
                                 input console_result_t pinned_result);
        console_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.op           <= op;
        cmd_bus.char_code    <= ch;
        cmd_bus.cell_address <= addr;
        do begin
            @(posedge i_clk);
        end while (!cmd_bus.ready);
        predicted = apply_command(op, ch, addr);
        pending_results.push_back(pinned ? pinned_result : predicted);
        @(negedge i_clk);
    endtask

    task automatic issue_random_command();
        int unsigned          pick;
        logic [OP_W-1:0]      op;
        logic [CHAR_W-1:0]    ch;
        logic [ADDR_IN_W-1:0] addr;
        pick = $urandom_range(99);
        op   = OP_PUT;
        ch   = CHAR_W'($urandom_range(255));
        addr = ADDR_IN_W'($urandom_range(2047));
        if (pick < 58) begin
            op = OP_PUT;
        end else if (pick < 62) begin
            ch = CH_LF;
        end else if (pick < 65) begin
            ch = CH_CR;
        end else if (pick < 71) begin
            ch = CH_BS;
        end else if (pick < 77) begin
            ch = CH_TAB;
        end else if (pick < 78) begin
            op = OP_CLEAR;
        end else if (pick < 80) begin
            op = OP_UNUSED;
        end else begin
            op = OP_READ;
            pick = $urandom_range(99);
            // half the time the cursor row, where recent writes land
            if (pick < 50) begin
                addr = ADDR_IN_W'(cur_row * COLUMNS + $urandom_range(COLUMNS - 1));
            end else if (pick < 90) begin
                addr = ADDR_IN_W'($urandom_range(CELL_COUNT - 1));
            end else begin
                addr = ADDR_IN_W'($urandom_range(2047, CELL_COUNT));
            end
        end
        issue_command(op, ch, addr, 1'b0, '0);
    endtask

    task automatic run_phase(input logic [ATTR_W-1:0] attr, input int unsigned idle_pct,
                             input int unsigned stall_pct, input bit with_hold);
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= attr;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        attr_model     = attr;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (with_hold && i == 40) begin
                hold_left = HOLD_CYCLES;
            end
            issue_random_command();
        end
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        console_result_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected transfer: word %h row %0d col %0d",
                                       rsp_bus.cell_word, rsp_bus.cursor_row,
                                       rsp_bus.cursor_col));
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.cell_word !== want.cell_word) begin
                    note_failure($sformatf("cell_word expected %h got %h",
                                           want.cell_word, rsp_bus.cell_word));
                end
                if (rsp_bus.cursor_row !== want.cursor_row) begin
                    note_failure($sformatf("cursor_row expected %0d got %0d",
                                           want.cursor_row, rsp_bus.cursor_row));
                end
                if (rsp_bus.cursor_col !== want.cursor_col) begin
                    note_failure($sformatf("cursor_col expected %0d got %0d",
                                           want.cursor_col, rsp_bus.cursor_col));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d transfers outstanding", pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        cmd_bus.valid        = 1'b0;
        cmd_bus.op           = OP_PUT;
        cmd_bus.char_code    = '0;
        cmd_bus.cell_address = '0;
        rsp_bus.ready        = 1'b0;
        attr_model           = ATTR_RESET;
        cur_row              = 0;
        cur_col              = 0;
        blank_screen();

        // reset state, range edges and the unused op
        table_row(OP_READ, 8'h00, 11'd0, 1, 1'b1, RESET_BLANK, 0, 0);
        table_row(OP_READ, 8'h00, ADDR_IN_W'(CELL_COUNT - 1), 1, 1'b1, RESET_BLANK, 0, 0);
        table_row(OP_READ, 8'hFF, 11'h7FF, 1, 1'b1, '0, 0, 0);
        table_row(OP_READ, 8'h00, ADDR_IN_W'(CELL_COUNT), 1, 1'b1, '0, 0, 0);
        table_row(OP_UNUSED, 8'hFF, 11'h7FF, 1, 1'b1, '0, 0, 0);
        // plain bytes including the high and zero codes
        table_row(OP_PUT, 8'h41, 11'h7FF, 1, 1'b1, '0, 0, 1);
        table_row(OP_PUT, 8'hFF, 11'd0, 1, 1'b1, '0, 0, 2);
        table_row(OP_PUT, 8'h00, 11'd0, 1, 1'b0, '0, 0, 0);
        table_row(OP_READ, 8'h00, 11'd1, 1, 1'b1, {ATTR_RESET, 8'hFF}, 0, 3);
        // control characters
        table_row(OP_PUT, CH_BS, 11'd0, 1, 1'b0, '0, 0, 0);
        table_row(OP_READ, 8'h00, 11'd2, 1, 1'b0, '0, 0, 0);
        table_row(OP_PUT, CH_TAB, 11'd0, 1, 1'b0, '0, 0, 0);
        table_row(OP_PUT, CH_CR, 11'd0, 1, 1'b1, '0, 0, 0);
        table_row(OP_PUT, CH_BS, 11'd0, 1, 1'b1, '0, 0, 0);
        table_row(OP_PUT, CH_LF, 11'd0, 1, 1'b1, '0, 1, 0);
        table_row(OP_PUT, 8'h80, 11'd0, 1, 1'b0, '0, 0, 0);
        table_row(OP_READ, 8'h00, ADDR_IN_W'(COLUMNS), 1, 1'b0, '0, 0, 0);
        // clear ignores char and address
        table_row(OP_CLEAR, 8'h41, 11'd5, 1, 1'b1, '0, 0, 0);
        table_row(OP_READ, 8'h00, 11'd0, 1, 1'b1, RESET_BLANK, 0, 0);
        // walk to the bottom row, then tab wrap and character wrap both scroll
        table_row(OP_PUT, CH_LF, 11'd0, ROWS - 1, 1'b0, '0, 0, 0);
        table_row(OP_PUT, 8'h7E, 11'd0, 3, 1'b0, '0, 0, 0);
        table_row(OP_PUT, CH_TAB, 11'd0, COLUMNS / 4 - 1, 1'b0, '0, 0, 0);
        table_row(OP_PUT, CH_TAB, 11'd0, 1, 1'b0, '0, 0, 0);
        table_row(OP_PUT, 8'h5A, 11'd0, COLUMNS, 1'b0, '0, 0, 0);
        table_row(OP_READ, 8'h00, ADDR_IN_W'((ROWS - 2) * COLUMNS), 1, 1'b0, '0, 0, 0);
        table_row(OP_READ, 8'h00, ADDR_IN_W'((ROWS - 1) * COLUMNS), 1, 1'b0, '0, 0, 0);
        table_row(OP_PUT, CH_BS, 11'd0, 1, 1'b0, '0, 0, 0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].repeats; k++) begin
                issue_command(directed_rows[r].op, directed_rows[r].char_code,
                              directed_rows[r].cell_address, directed_rows[r].pinned,
                              directed_rows[r].pinned_result);
            end
        end

        run_phase(8'hFF, 0, 0, 1'b1);
        run_phase(8'h00, 54, 0, 1'b0);
        run_phase(ATTR_W'($urandom_range(254, 1)), 0, 54, 1'b0);
        run_phase(ATTR_W'($urandom_range(255)), 7, 7, 1'b0);

        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
